[hdl/slot_pool_free_stack_core_defines.svh]
`ifndef SLOT_POOL_FREE_STACK_CORE_DEFINES_SVH
`define SLOT_POOL_FREE_STACK_CORE_DEFINES_SVH

// cond implies expr in the same cycle
`define SPS_ASSERT_HOLD(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("slot pool check failed");

// cond implies expr in the next cycle
`define SPS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("slot pool check failed");

`endif

[hdl/sps_pkg.sv]
package sps_pkg;

   localparam int POOL_SLOTS = 64;
   localparam int SLOT_W     = 6;
   localparam int CNT_W      = 7;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_INIT    = 2'd2,
      ACT_NOP     = 2'd3
   } sps_action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 2'd0,
      ST_EMPTY        = 2'd1,
      ST_UNKNOWN      = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } sps_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_FILL,
      S_DONE
   } sps_state_type;

endpackage

[hdl/sps_req_if.sv]
interface sps_req_if;
   logic                       valid;
   logic                       ready;
   logic [sps_pkg::ACT_W-1:0]  action;
   logic [sps_pkg::SLOT_W-1:0] slot_in;

   modport source (output valid, output action, output slot_in, input ready);
   modport sink   (input valid, input action, input slot_in, output ready);
endinterface

[hdl/sps_rsp_if.sv]
interface sps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sps_pkg::SLOT_W-1:0] slot_out;
   logic [sps_pkg::STAT_W-1:0] status;
   logic [sps_pkg::CNT_W-1:0]  free_count;
   logic [sps_pkg::CNT_W-1:0]  low_water;

   modport source (output valid, output slot_out, output status, output free_count,
                   output low_water, input ready);
   modport sink   (input valid, input slot_out, input status, input free_count,
                   input low_water, output ready);
endinterface

[hdl/sps_stack_mem.sv]
module sps_stack_mem (
   input  logic                       clock,
   input  logic                       we,
   input  logic [sps_pkg::SLOT_W-1:0] waddr,
   input  logic [sps_pkg::SLOT_W-1:0] wdata,
   input  logic                       re,
   input  logic [sps_pkg::SLOT_W-1:0] raddr,
   output logic [sps_pkg::SLOT_W-1:0] rdata
);
   import sps_pkg::*;

   logic [SLOT_W-1:0] stack_mem [0:POOL_SLOTS-1];
   logic [SLOT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         stack_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= stack_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/slot_pool_free_stack_core.sv]
// Allocate with a free slot: stack read, busy mark, then result, from input transfer to result
// transfer. Empty allocate, release and no-op go straight to the result; initialize: one stack
// write per cycle for each of the capped slot_count slots through the shared stack pointer adder.
// One item at a time; the next input transfer is taken once the result is registered.
// Reset (synchronous): empty stack, all slots busy, low-water mark and slot_count zero.
`include "slot_pool_free_stack_core_defines.svh"

module slot_pool_free_stack_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [sps_pkg::CNT_W-1:0] csr_wdata,
   sps_req_if.sink                   req_if,
   sps_rsp_if.source                 rsp_if
);
   import sps_pkg::*;

   sps_state_type             state_ff, state_in;
   logic [CNT_W-1:0]          slot_count_ff;
   logic [CNT_W-1:0]          top_ff, top_in;
   logic [CNT_W-1:0]          fewest_ff, fewest_in;
   logic [POOL_SLOTS-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [SLOT_W-1:0]         res_slot_ff, res_slot_in;
   sps_status_type            res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic [STAT_W-1:0]         rsp_status_ff;
   logic [CNT_W-1:0]          rsp_free_ff;
   logic [CNT_W-1:0]          rsp_low_ff;

   logic                      req_fire;
   logic                      rsp_load;
   logic [CNT_W-1:0]          pool_sz;
   logic                      top_down;
   logic [CNT_W-1:0]          top_step;
   sps_action_type            req_action;

   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr;
   logic [SLOT_W-1:0]         mem_wdata;
   logic                      mem_re;
   logic [SLOT_W-1:0]         mem_rdata;

   sps_stack_mem u_stack (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (top_step[SLOT_W-1:0]),
      .rdata (mem_rdata)
   );

   assign req_action    = sps_action_type'(req_if.action);
   assign req_if.ready  = (state_ff == S_IDLE);
   assign req_fire      = req_if.valid && req_if.ready;
   assign rsp_load      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   assign pool_sz  = (slot_count_ff > CNT_W'(POOL_SLOTS)) ? CNT_W'(POOL_SLOTS) : slot_count_ff;

   // shared stack pointer adder
   assign top_down = (state_ff == S_IDLE) && (req_action == ACT_ALLOC);
   assign top_step = top_ff + (top_down ? {CNT_W{1'b1}} : CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_ALLOC && top_ff != '0) begin
                  state_in = S_POP;
               end else if (req_action == ACT_INIT) begin
                  state_in = S_FILL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_POP: state_in = S_DONE;
         S_FILL: begin
            if (top_ff == n_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      top_in        = top_ff;
      fewest_in     = fewest_ff;
      free_in       = free_ff;
      n_in          = n_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = top_ff[SLOT_W-1:0];
      mem_wdata     = req_if.slot_in;
      mem_re        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_slot_in   = req_if.slot_in;
               res_status_in = ST_OK;
               case (req_action)
                  ACT_ALLOC: begin
                     if (top_ff == '0) begin
                        res_slot_in   = '0;
                        res_status_in = ST_EMPTY;
                     end else begin
                        top_in = top_step;
                        mem_re = 1'b1;
                        if (top_step < fewest_ff) begin
                           fewest_in = top_step;
                        end
                     end
                  end
                  ACT_RELEASE: begin
                     if ({1'b0, req_if.slot_in} >= pool_sz) begin
                        res_status_in = ST_UNKNOWN;
                     end else if (free_ff[req_if.slot_in]) begin
                        res_status_in = ST_ALREADY_FREE;
                     end else begin
                        mem_we                  = 1'b1;
                        free_in[req_if.slot_in] = 1'b1;
                        top_in                  = top_step;
                     end
                  end
                  ACT_INIT: begin
                     top_in  = '0;
                     free_in = '0;
                     n_in    = pool_sz;
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            res_slot_in        = mem_rdata;
            free_in[mem_rdata] = 1'b0;
         end
         S_FILL: begin
            if (top_ff != n_ff) begin
               mem_we                        = 1'b1;
               mem_wdata                     = top_ff[SLOT_W-1:0];
               free_in[top_ff[SLOT_W-1:0]]   = 1'b1;
               top_in                        = top_step;
            end else begin
               fewest_in = top_ff;
            end
         end
         S_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= '0;
         top_ff        <= '0;
         fewest_ff     <= '0;
         free_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            slot_count_ff <= csr_wdata;
         end
         top_ff        <= top_in;
         fewest_ff     <= fewest_in;
         free_ff       <= free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_free_ff   <= top_ff;
         rsp_low_ff    <= fewest_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.slot_out   = rsp_slot_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.free_count = rsp_free_ff;
   assign rsp_if.low_water  = rsp_low_ff;

   `SPS_ASSERT_HOLD(a_top_bound, 1'b1, top_ff <= CNT_W'(POOL_SLOTS))
   `SPS_ASSERT_HOLD(a_low_water, state_ff == S_IDLE, fewest_ff <= top_ff)
   `SPS_ASSERT_HOLD(a_free_bits, state_ff == S_IDLE, $countones(free_ff) == int'(top_ff))
   `SPS_ASSERT_HOLD(a_fill_bound, state_ff == S_FILL, top_ff <= n_ff)
   `SPS_ASSERT_NEXT(a_leave_idle, req_fire, state_ff != S_IDLE)

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import sps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 31;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      sps_status_type    status;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  low_water;
   } pool_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CNT_W-1:0] csr_wdata;

   sps_req_if req_bus ();
   sps_rsp_if rsp_bus ();

   slot_pool_free_stack_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   // pool mirror
   logic [SLOT_W-1:0] mirror_stack [POOL_SLOTS];
   bit                mirror_free  [POOL_SLOTS];
   int unsigned       mirror_depth;
   int unsigned       mirror_low;
   logic [CNT_W-1:0]  mirror_count;

   pool_result_type expected_results [$];

   bit no_idle;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned ops_sent;
   int unsigned results_seen = 0;
   int unsigned count_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   always @(negedge clock)
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

   function automatic int unsigned pool_size();
      return (mirror_count > POOL_SLOTS) ? POOL_SLOTS : mirror_count;
   endfunction

   function automatic pool_result_type predict_pool_result(sps_action_type act,
                                                           logic [SLOT_W-1:0] slot);
      pool_result_type r;
      int unsigned n;
      n = pool_size();
      r.slot_out = slot;
      r.status   = ST_OK;
      case (act)
         ACT_INIT: begin
            mirror_depth = 0;
            for (int i = 0; i < POOL_SLOTS; i++) mirror_free[i] = 1'b0;
            for (int i = 0; i < n; i++) begin
               mirror_stack[mirror_depth] = SLOT_W'(i);
               mirror_free[i] = 1'b1;
               mirror_depth++;
            end
            mirror_low = mirror_depth;
         end
         ACT_ALLOC: begin
            if (mirror_depth == 0) begin
               r.status   = ST_EMPTY;
               r.slot_out = '0;
            end else begin
               mirror_depth--;
               r.slot_out = mirror_stack[mirror_depth];
               mirror_free[r.slot_out] = 1'b0;
               if (mirror_depth < mirror_low) mirror_low = mirror_depth;
            end
         end
         ACT_RELEASE: begin
            if (slot >= n) begin
               r.status = ST_UNKNOWN;
            end else if (mirror_free[slot]) begin
               r.status = ST_ALREADY_FREE;
            end else if (mirror_depth < POOL_SLOTS) begin
               mirror_stack[mirror_depth] = slot;
               mirror_free[slot] = 1'b1;
               mirror_depth++;
            end
         end
         default: ;
      endcase
      r.free_count = CNT_W'(mirror_depth);
      r.low_water  = CNT_W'(mirror_low);
      return r;
   endfunction

   function automatic int pick_busy_slot();
      int busy [$];
      for (int i = 0; i < pool_size(); i++)
         if (!mirror_free[i]) busy.push_back(i);
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(0, busy.size() - 1)];
   endfunction

   always @(posedge clock) begin
      pool_result_type got;
      pool_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.slot_out   = rsp_bus.slot_out;
         got.status     = sps_status_type'(rsp_bus.status);
         got.free_count = rsp_bus.free_count;
         got.low_water  = rsp_bus.low_water;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: result with nothing pending: slot %0d status %0d free %0d low %0d",
                        $realtime, got.slot_out, got.status, got.free_count, got.low_water);
         end else begin
            want = expected_results.pop_front();
            if (got.slot_out !== want.slot_out || got.status !== want.status ||
                got.free_count !== want.free_count || got.low_water !== want.low_water) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"%0t: result mismatch: slot exp %0d act %0d, status exp %0d act %0d,",
                            " free exp %0d act %0d, low exp %0d act %0d"}, $realtime,
                           want.slot_out, got.slot_out, want.status, got.status,
                           want.free_count, got.free_count, want.low_water, got.low_water);
            end
         end
      end
   end

   task automatic issue_pool_op(sps_action_type act, logic [SLOT_W-1:0] slot);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.slot_in <= slot;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_pool_result(act, slot));
      ops_sent++;
      @(negedge clock);
   endtask

   task automatic wait_pool_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_slot_count(logic [CNT_W-1:0] value);
      wait_pool_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      mirror_count = value;
      count_writes++;
   endtask

   task automatic test_empty_pool();
      issue_pool_op(ACT_ALLOC, 6'd0);
      issue_pool_op(ACT_RELEASE, 6'd0);
      issue_pool_op(ACT_NOP, 6'd63);
      issue_pool_op(ACT_INIT, 6'd21);
      issue_pool_op(ACT_ALLOC, 6'd63);
   endtask

   task automatic test_pool_extremes();
      set_slot_count(CNT_W'(POOL_SLOTS));
      issue_pool_op(ACT_INIT, 6'd0);
      issue_pool_op(ACT_ALLOC, 6'd0);
      issue_pool_op(ACT_ALLOC, 6'd0);
      issue_pool_op(ACT_RELEASE, 6'd63);
      issue_pool_op(ACT_RELEASE, 6'd63);
      issue_pool_op(ACT_RELEASE, 6'd0);
      set_slot_count(7'd127);
      issue_pool_op(ACT_INIT, 6'd63);
      issue_pool_op(ACT_ALLOC, 6'd0);
      issue_pool_op(ACT_RELEASE, 6'd63);
   endtask

   task automatic test_count_change();
      set_slot_count(7'd4);
      issue_pool_op(ACT_INIT, 6'd0);
      set_slot_count(7'd10);
      issue_pool_op(ACT_RELEASE, 6'd7);
      issue_pool_op(ACT_RELEASE, 6'd7);
      issue_pool_op(ACT_RELEASE, 6'd10);
      issue_pool_op(ACT_ALLOC, 6'd0);
      set_slot_count(7'd1);
      issue_pool_op(ACT_INIT, 6'd0);
      issue_pool_op(ACT_ALLOC, 6'd0);
      issue_pool_op(ACT_ALLOC, 6'd0);
      issue_pool_op(ACT_RELEASE, 6'd0);
      set_slot_count(7'd0);
      issue_pool_op(ACT_INIT, 6'd0);
      issue_pool_op(ACT_ALLOC, 6'd5);
   endtask

   task automatic test_random_traffic();
      logic [CNT_W-1:0] phase_counts [8];
      int roll;
      int slot;
      phase_counts = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd17, 7'd64, 7'd0, 7'd0};
      phase_counts[6] = CNT_W'($urandom_range(0, 127));
      for (int p = 0; p < 8; p++) begin
         set_slot_count(phase_counts[p]);
         no_idle = (p == 5);
         issue_pool_op(ACT_INIT, SLOT_W'($urandom));
         for (int k = 0; k < 62; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               issue_pool_op(ACT_ALLOC, SLOT_W'($urandom));
            end else if (roll < 85) begin
               slot = pick_busy_slot();
               if (slot < 0) slot = $urandom_range(0, POOL_SLOTS - 1);
               issue_pool_op(ACT_RELEASE, SLOT_W'(slot));
            end else if (roll < 93) begin
               issue_pool_op(ACT_RELEASE, SLOT_W'($urandom));
            end else if (roll < 97) begin
               issue_pool_op(ACT_NOP, SLOT_W'($urandom));
            end else begin
               issue_pool_op(ACT_INIT, SLOT_W'($urandom));
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_NOP;
      req_bus.slot_in = '0;
      no_idle         = 1'b0;
      ops_sent        = 0;
      count_writes    = 0;
      mirror_depth    = 0;
      mirror_low      = 0;
      mirror_count    = '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         mirror_free[i]  = 1'b0;
         mirror_stack[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_pool();
      test_pool_extremes();
      test_count_change();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Sent %0d pool operations over %0d slot_count settings; checked %0d results",
               ops_sent, count_writes, results_seen);
      $display("Mismatch count: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
